// ----- design/mrf_pkg.sv -----
`default_nettype none

package mrf_pkg;

    // Depth of the request queue between the front and the back
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int PDU_W = 48;

    typedef enum logic [2:0] {
        ACT_READ_COILS     = 3'd0,
        ACT_READ_INPUTS    = 3'd1,
        ACT_READ_HOLDING   = 3'd2,
        ACT_READ_INPUT_REG = 3'd3,
        ACT_WRITE_COIL     = 3'd4,
        ACT_WRITE_REG      = 3'd5
    } t_action;

    // One classified request, ready to be framed
    typedef struct packed {
        logic             ascii;
        logic [PDU_W-1:0] pdu;   // slave, function, start hi/lo, operand hi/lo
    } t_req;

endpackage

`default_nettype wire

// ----- design/mrf_front.sv -----
`default_nettype none

module mrf_front
    import mrf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_ascii_mode,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_action,
    input  wire logic [7:0]  i_slave_address,
    input  wire logic [15:0] i_reg_addr,
    input  wire logic [15:0] i_operand,
    output logic             o_q_valid,
    input  wire logic        i_q_ready,
    output t_req             o_q_data
);

    logic r_valid;
    t_req r_req;
    t_req n_req;
    logic [7:0]  func_code;
    logic [15:0] opnd;

    always_comb begin
        func_code = {5'd0, i_action} + 8'd1;
        if (i_action == ACT_WRITE_COIL) begin
            opnd = (i_operand != 16'd0) ? 16'hFF00 : 16'h0000;
        end else begin
            opnd = i_operand;
        end
        n_req.ascii = i_ascii_mode;
        n_req.pdu   = {i_slave_address, func_code, i_reg_addr, opnd};
    end

    assign o_ready   = !r_valid || i_q_ready;
    assign o_q_valid = r_valid;
    assign o_q_data  = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= n_req;
        end
    end

endmodule

`default_nettype wire

// ----- design/mrf_queue.sv -----
`default_nettype none

module mrf_queue
    import mrf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_req i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_req      o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_req          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- design/mrf_back.sv -----
`default_nettype none

module mrf_back
    import mrf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    output logic      o_q_ready,
    input  wire t_req i_q_data,
    output logic       o_tvalid,
    input  wire logic  i_tready,
    output logic [7:0] o_tdata,
    output logic       o_tlast
);

    localparam logic [4:0]  RTU_CRC_LO  = 5'd6;
    localparam logic [4:0]  RTU_LAST    = 5'd7;
    localparam logic [4:0]  ASC_PDU_END = 5'd12;
    localparam logic [4:0]  ASC_LRC_HI  = 5'd13;
    localparam logic [4:0]  ASC_LRC_LO  = 5'd14;
    localparam logic [4:0]  ASC_CR_POS  = 5'd15;
    localparam logic [4:0]  ASC_LAST    = 5'd16;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]  CH_COLON    = 8'h3A;
    localparam logic [7:0]  CH_CR       = 8'h0D;
    localparam logic [7:0]  CH_LF       = 8'h0A;

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
    endfunction

    function automatic logic [7:0] pdu_byte(input logic [PDU_W-1:0] pdu, input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = pdu[47:40];
            3'd1:    b = pdu[39:32];
            3'd2:    b = pdu[31:24];
            3'd3:    b = pdu[23:16];
            3'd4:    b = pdu[15:8];
            3'd5:    b = pdu[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    logic        r_busy;
    logic [4:0]  r_pos;
    t_req        r_req;
    logic [15:0] r_crc;
    logic [7:0]  r_lrc;
    logic        r_ovalid;
    logic [7:0]  r_odata;
    logic        r_olast;

    logic        advance;
    logic        have;
    logic        fire;
    t_req        cur;
    logic [4:0]  pos;
    logic [4:0]  pos_m1;
    logic [15:0] crc;
    logic [7:0]  lrc;
    logic [7:0]  lrc_val;
    logic [7:0]  pb;
    logic [7:0]  n_odata;
    logic        n_olast;
    logic [15:0] n_crc;
    logic [7:0]  n_lrc;

    always_comb begin
        advance = !r_ovalid || i_tready;
        have    = r_busy || i_q_valid;
        fire    = advance && have;
        // idle: frame the queue head directly so frames run without a gap
        cur     = r_busy ? r_req : i_q_data;
        pos     = r_busy ? r_pos : 5'd0;
        crc     = r_busy ? r_crc : CRC_INIT;
        lrc     = r_busy ? r_lrc : 8'd0;
        pos_m1  = pos - 5'd1;
        lrc_val = 8'd0 - lrc;
        pb      = pdu_byte(cur.pdu, cur.ascii ? pos_m1[3:1] : pos[2:0]);
        n_crc   = crc;
        n_lrc   = lrc;
        n_olast = 1'b0;
        n_odata = 8'd0;
        if (cur.ascii) begin
            if (pos == 5'd0) begin
                n_odata = CH_COLON;
            end else if (pos <= ASC_PDU_END) begin
                n_odata = pos[0] ? hex_char(pb[7:4]) : hex_char(pb[3:0]);
                if (pos[0]) begin
                    n_lrc = lrc + pb;
                end
            end else if (pos == ASC_LRC_HI) begin
                n_odata = hex_char(lrc_val[7:4]);
            end else if (pos == ASC_LRC_LO) begin
                n_odata = hex_char(lrc_val[3:0]);
            end else if (pos == ASC_CR_POS) begin
                n_odata = CH_CR;
            end else begin
                n_odata = CH_LF;
                n_olast = 1'b1;
            end
        end else begin
            if (pos < RTU_CRC_LO) begin
                n_odata = pb;
                n_crc   = crc_step(crc, pb);
            end else if (pos == RTU_CRC_LO) begin
                n_odata = crc[7:0];
            end else begin
                n_odata = crc[15:8];
                n_olast = 1'b1;
            end
        end
    end

    assign o_q_ready = advance && !r_busy;
    assign o_tvalid  = r_ovalid;
    assign o_tdata   = r_odata;
    assign o_tlast   = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pos    <= 5'd0;
            r_ovalid <= 1'b0;
        end else if (advance) begin
            r_ovalid <= have;
            if (have) begin
                r_busy <= !n_olast;
                r_pos  <= n_olast ? 5'd0 : pos + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_req   <= cur;
            r_crc   <= n_crc;
            r_lrc   <= n_lrc;
            r_odata <= n_odata;
            r_olast <= n_olast;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos != 5'd0 && (r_req.ascii ? (r_pos <= ASC_LAST) : (r_pos <= RTU_LAST))))
        else $error("frame position out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_tready) |=> (r_busy == $past(r_busy) && r_pos == $past(r_pos)))
        else $error("serializer advanced while output stalled");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_olast) |-> !r_busy)
        else $error("frame still busy after its last byte");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_ready && i_q_valid) |=> (r_ovalid && (r_busy || r_olast)))
        else $error("queue pop did not start a frame");

endmodule

`default_nettype wire

// ----- design/modbus_request_framer_core.sv -----
`default_nettype none

// Channel     Dir  Handshake                      Payload
// s_axis      in   s_axis_tvalid / s_axis_tready  request: action, slave, start, operand
// m_axis      out  m_axis_tvalid / m_axis_tready  frame byte, tlast on final byte
// cfg         in   i_cfg_we                       ascii_mode
//
// One frame byte per cycle while m_axis is not stalled: 8 bytes per request in RTU
// mode, 17 in ASCII; the serializer folds each PDU byte into the CRC or LRC.
// Reset: synchronous, with i_rst_n low; config returns to RTU mode.
// Requests are buffered in a front stage plus a small queue, so the input keeps
// accepting while m_axis stalls until both fill; frames follow with no idle cycle.

module modbus_request_framer_core
    import mrf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,      // [0] ascii_mode
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] action, [10:3] slave_address, [26:11] reg_addr,
    // [42:27] operand, [47:43] zero
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,     // [7:0] frame_byte
    output logic             m_axis_tlast      // last_byte
);

    logic r_ascii_mode;
    logic f_valid;
    logic f_ready;
    t_req f_data;
    logic q_valid;
    logic q_ready;
    t_req q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ascii_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_ascii_mode <= i_cfg_wdata;
        end
    end

    mrf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ascii_mode    (r_ascii_mode),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_action        (s_axis_tdata[2:0]),
        .i_slave_address (s_axis_tdata[10:3]),
        .i_reg_addr      (s_axis_tdata[26:11]),
        .i_operand       (s_axis_tdata[42:27]),
        .o_q_valid       (f_valid),
        .i_q_ready       (f_ready),
        .o_q_data        (f_data)
    );

    mrf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    mrf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_data  (q_data),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tlast   (m_axis_tlast)
    );

endmodule

`default_nettype wire
